### hdl/mmcal_pkg.sv
package mmcal_pkg;

  // Field and sample format.
  localparam int DATA_W      = 16;
  localparam int FRAC_BITS   = 12;
  localparam int SAMPLE_BITS = 16;
  localparam int SAMPLE_SHIFT = DATA_W - SAMPLE_BITS;

  // Divider widths. The quotient needs one bit past the output range so that
  // clipping can be detected; anything wider is caught before the division.
  localparam int NUM_W = DATA_W + 2;
  localparam int DEN_W = DATA_W + 1;
  localparam int MAG_W = DATA_W;
  localparam int QUO_W = DATA_W + 1;
  localparam int UN_W  = NUM_W + FRAC_BITS;
  localparam int HI_W  = UN_W - QUO_W;
  localparam int CNT_W = $clog2(QUO_W);

  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [QUO_W-1:0] QUO_POS_LIMIT = QUO_W'(2**(DATA_W-1) - 1);
  localparam logic [QUO_W-1:0] QUO_NEG_LIMIT = QUO_W'(2**(DATA_W-1));

  localparam logic MODE_CAL   = 1'b0;
  localparam logic MODE_APPLY = 1'b1;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FIN,
    ST_WRITE
  } state_e;

endpackage

### hdl/magnetometer_min_max_calibration.sv
// Two-axis magnetometer hard-iron calibration by min/max tracking. A calibration
// request (mode 0) widens the running x/y extremes; with last set, the extremes
// are committed as the calibration and the trackers return to their reset
// values. An apply request (mode 1) returns (2v - high - low) / (high - low) per
// axis in signed fixed point with FRAC_BITS fraction bits, truncated toward zero
// and clipped to 16 bits; a zero span gives 0 and sets that axis's flag. Every
// request yields exactly one result, held in an output register until taken. The
// block works on one request at a time: a calibration request goes from
// acceptance to the write state, an apply request first through the divider for
// both axes. The apply time is set by one shared restoring divider that
// produces one quotient bit per cycle for x and then for y; each axis passes a
// setup step, 17 division steps and a finishing step, and an axis with zero
// span or a quotient beyond 17 bits takes only its setup step. The write state
// waits while a previous result is still held untaken. A new request is taken
// once the previous one has reached the result register.
module magnetometer_min_max_calibration
  import mmcal_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     mode_i,
  input  logic signed [DATA_W-1:0] x_sample_i,
  input  logic signed [DATA_W-1:0] y_sample_i,
  input  logic                     last_i,

  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     result_kind_o,
  output logic signed [DATA_W-1:0] norm_x_o,
  output logic signed [DATA_W-1:0] norm_y_o,
  output logic                     x_zero_span_o,
  output logic                     y_zero_span_o,
  output logic                     saturated_o,
  output logic signed [DATA_W-1:0] x_high_o,
  output logic signed [DATA_W-1:0] x_low_o,
  output logic signed [DATA_W-1:0] y_high_o,
  output logic signed [DATA_W-1:0] y_low_o
);

  state_e state_q, state_d;

  // Latched request.
  logic                     mode_q;
  logic                     last_q;
  logic signed [DATA_W-1:0] x_q;
  logic signed [DATA_W-1:0] y_q;

  // Trackers and committed calibration.
  logic signed [DATA_W-1:0] trk_xh_q, trk_xl_q, trk_yh_q, trk_yl_q;
  logic signed [DATA_W-1:0] cal_xh_q, cal_xl_q, cal_yh_q, cal_yl_q;

  // Divider and per-request results.
  logic                     axis_q;
  logic                     neg_q;
  logic [MAG_W-1:0]         ud_q;
  logic [MAG_W-1:0]         rem_q;
  logic [QUO_W-1:0]         dvd_q;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [DATA_W-1:0] nx_q, ny_q;
  logic                     zx_q, zy_q, sat_q;

  logic out_valid_q;

  // Control decoded from the state.
  logic in_take;
  logic out_load;

  // Sample sign extension from SAMPLE_BITS.
  logic signed [DATA_W-1:0] x_shl, y_shl, x_ext, y_ext;

  // Operand selection and setup for the current axis.
  logic signed [DATA_W-1:0] v_sel, hi_sel, lo_sel;
  logic signed [NUM_W-1:0]  num;
  logic signed [DEN_W-1:0]  den;
  logic [NUM_W-1:0]         num_mag;
  logic [DEN_W-1:0]         den_mag;
  logic [UN_W-1:0]          un;
  logic [MAG_W-1:0]         ud;
  logic                     den_zero;
  logic                     quo_big;

  // One restoring step.
  logic [MAG_W:0]           trial;
  logic                     take_bit;

  // Final quotient handling.
  logic                     fin_sat;
  logic signed [DATA_W-1:0] fin_val;

  // Tracker update for a calibration request.
  logic signed [DATA_W-1:0] new_xh, new_xl, new_yh, new_yl;

  assign x_shl = x_sample_i <<< SAMPLE_SHIFT;
  assign y_shl = y_sample_i <<< SAMPLE_SHIFT;
  assign x_ext = x_shl >>> SAMPLE_SHIFT;
  assign y_ext = y_shl >>> SAMPLE_SHIFT;

  assign v_sel  = (axis_q == AXIS_Y) ? y_q      : x_q;
  assign hi_sel = (axis_q == AXIS_Y) ? cal_yh_q : cal_xh_q;
  assign lo_sel = (axis_q == AXIS_Y) ? cal_yl_q : cal_xl_q;

  assign num = (NUM_W'(v_sel) <<< 1) - NUM_W'(hi_sel) - NUM_W'(lo_sel);
  assign den = DEN_W'(hi_sel) - DEN_W'(lo_sel);
  assign num_mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign den_mag  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
  assign un       = UN_W'(num_mag) << FRAC_BITS;
  assign ud       = den_mag[MAG_W-1:0];
  assign den_zero = (den == '0);
  // A quotient of 2**QUO_W or more is clipped without dividing.
  assign quo_big  = (MAG_W'(un[UN_W-1:QUO_W]) >= ud);

  assign trial    = {rem_q, dvd_q[QUO_W-1]} - {1'b0, ud_q};
  assign take_bit = ~trial[MAG_W];

  always_comb begin
    if (!neg_q) begin
      fin_sat = (dvd_q > QUO_POS_LIMIT);
      fin_val = fin_sat ? VAL_MAX : DATA_W'(dvd_q);
    end else begin
      fin_sat = (dvd_q > QUO_NEG_LIMIT);
      fin_val = fin_sat ? VAL_MIN : DATA_W'(-dvd_q);
    end
  end

  assign new_xh = (x_q > trk_xh_q) ? x_q : trk_xh_q;
  assign new_xl = (x_q < trk_xl_q) ? x_q : trk_xl_q;
  assign new_yh = (y_q > trk_yh_q) ? y_q : trk_yh_q;
  assign new_yl = (y_q < trk_yl_q) ? y_q : trk_yl_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (mode_i == MODE_APPLY) ? ST_PREP : ST_WRITE;
        end
      end
      ST_PREP: begin
        if (den_zero || quo_big) begin
          state_d = (axis_q == AXIS_Y) ? ST_WRITE : ST_PREP;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = (axis_q == AXIS_Y) ? ST_WRITE : ST_PREP;
      end
      ST_WRITE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_take  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_take  = in_valid_i;
      ST_WRITE: out_load = ~out_valid_q | out_ready_i;
      default: begin
        in_take  = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      trk_xh_q    <= VAL_MIN;
      trk_xl_q    <= VAL_MAX;
      trk_yh_q    <= VAL_MIN;
      trk_yl_q    <= VAL_MAX;
      cal_xh_q    <= '0;
      cal_xl_q    <= '0;
      cal_yh_q    <= '0;
      cal_yl_q    <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (out_load && mode_q == MODE_CAL) begin
        if (last_q) begin
          cal_xh_q <= new_xh;
          cal_xl_q <= new_xl;
          cal_yh_q <= new_yh;
          cal_yl_q <= new_yl;
          trk_xh_q <= VAL_MIN;
          trk_xl_q <= VAL_MAX;
          trk_yh_q <= VAL_MIN;
          trk_yl_q <= VAL_MAX;
        end else begin
          trk_xh_q <= new_xh;
          trk_xl_q <= new_xl;
          trk_yh_q <= new_yh;
          trk_yl_q <= new_yl;
        end
      end
    end
  end

  // Request latch and divider datapath.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q <= mode_i;
      last_q <= last_i;
      x_q    <= x_ext;
      y_q    <= y_ext;
      axis_q <= AXIS_X;
      nx_q   <= '0;
      ny_q   <= '0;
      zx_q   <= 1'b0;
      zy_q   <= 1'b0;
      sat_q  <= 1'b0;
    end

    if (state_q == ST_PREP) begin
      neg_q <= num[NUM_W-1] ^ den[DEN_W-1];
      ud_q  <= ud;
      rem_q <= MAG_W'(un[UN_W-1:QUO_W]);
      dvd_q <= un[QUO_W-1:0];
      cnt_q <= CNT_W'(QUO_W - 1);
      if (den_zero) begin
        if (axis_q == AXIS_Y) begin
          zy_q <= 1'b1;
        end else begin
          zx_q <= 1'b1;
        end
      end else if (quo_big) begin
        sat_q <= 1'b1;
        if (axis_q == AXIS_Y) begin
          ny_q <= (num[NUM_W-1] ^ den[DEN_W-1]) ? VAL_MIN : VAL_MAX;
        end else begin
          nx_q <= (num[NUM_W-1] ^ den[DEN_W-1]) ? VAL_MIN : VAL_MAX;
        end
      end
      if (den_zero || quo_big) begin
        axis_q <= AXIS_Y;
      end
    end

    if (state_q == ST_DIV) begin
      if (take_bit) begin
        rem_q <= trial[MAG_W-1:0];
      end else begin
        rem_q <= {rem_q[MAG_W-2:0], dvd_q[QUO_W-1]};
      end
      dvd_q <= {dvd_q[QUO_W-2:0], take_bit};
      cnt_q <= cnt_q - 1'b1;
    end

    if (state_q == ST_FIN) begin
      if (fin_sat) begin
        sat_q <= 1'b1;
      end
      if (axis_q == AXIS_Y) begin
        ny_q <= fin_val;
      end else begin
        nx_q <= fin_val;
      end
      axis_q <= AXIS_Y;
    end

    if (out_load) begin
      result_kind_o <= mode_q;
      norm_x_o      <= nx_q;
      norm_y_o      <= ny_q;
      x_zero_span_o <= zx_q;
      y_zero_span_o <= zy_q;
      saturated_o   <= sat_q;
      if (mode_q == MODE_CAL) begin
        x_high_o <= new_xh;
        x_low_o  <= new_xl;
        y_high_o <= new_yh;
        y_low_o  <= new_yl;
      end else begin
        x_high_o <= trk_xh_q;
        x_low_o  <= trk_xl_q;
        y_high_o <= trk_yh_q;
        y_low_o  <= trk_yl_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mmcal_pkg::*;

  localparam int     CLK_HALF      = 5;
  localparam int     RESET_CYCLES  = 5;
  localparam int     SETTLE_CYCLES = 60;
  localparam longint CYCLE_LIMIT   = 400000;
  localparam int     RANDOM_ITEMS  = 825;
  localparam int     MAX_PRINTED   = 100;
  localparam int     DIRECTED_ROWS = 25;

  typedef logic signed [DATA_W-1:0] sample_t;

  typedef struct {
    logic    kind;
    sample_t nx;
    sample_t ny;
    logic    zx;
    logic    zy;
    logic    sat;
    sample_t xh;
    sample_t xl;
    sample_t yh;
    sample_t yl;
  } mag_result_t;

  typedef struct {
    logic        mode;
    sample_t     x;
    sample_t     y;
    logic        last;
    bit          typed;
    mag_result_t want;
  } stim_row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    in_valid_i;
  logic    in_ready_o;
  logic    mode_i;
  sample_t x_sample_i;
  sample_t y_sample_i;
  logic    last_i;
  logic    out_valid_o;
  logic    out_ready_i = 1'b0;
  logic    result_kind_o;
  sample_t norm_x_o;
  sample_t norm_y_o;
  logic    x_zero_span_o;
  logic    y_zero_span_o;
  logic    saturated_o;
  sample_t x_high_o;
  sample_t x_low_o;
  sample_t y_high_o;
  sample_t y_low_o;

  // Predicted block state: running extremes and committed calibration.
  sample_t trk_xh = VAL_MIN;
  sample_t trk_xl = VAL_MAX;
  sample_t trk_yh = VAL_MIN;
  sample_t trk_yl = VAL_MAX;
  sample_t cal_xh = '0;
  sample_t cal_xl = '0;
  sample_t cal_yh = '0;
  sample_t cal_yl = '0;

  mag_result_t pending_q[$];
  mag_result_t blank_result = '{default: '0};
  int          error_count = 0;
  int          results_seen = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  longint      cycle_count = 0;

  // Directed requests: extremes, both modes, zero span, clipping and the
  // exact negative limit. Rows with typed=1 carry a hand-written result.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{MODE_APPLY, 16'sd0, 16'sd0, 1'b0, 1'b1,
      '{MODE_APPLY, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b0, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX}},
    '{MODE_APPLY, VAL_MAX, VAL_MIN, 1'b1, 1'b1,
      '{MODE_APPLY, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b0, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX}},
    '{MODE_CAL, VAL_MAX, VAL_MIN, 1'b0, 1'b1,
      '{MODE_CAL, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, VAL_MAX, VAL_MAX, VAL_MIN, VAL_MIN}},
    '{MODE_CAL, VAL_MIN, VAL_MAX, 1'b1, 1'b1,
      '{MODE_CAL, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN}},
    '{MODE_APPLY, VAL_MAX, VAL_MIN, 1'b0, 1'b1,
      '{MODE_APPLY, 16'sd4096, -16'sd4096, 1'b0, 1'b0, 1'b0,
        VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX}},
    '{MODE_APPLY, VAL_MIN, VAL_MAX, 1'b0, 1'b1,
      '{MODE_APPLY, -16'sd4096, 16'sd4096, 1'b0, 1'b0, 1'b0,
        VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX}},
    '{MODE_APPLY, 16'sd0, 16'sd0, 1'b0, 1'b0, '{default: '0}},
    '{MODE_APPLY, 16'sh5a5a, -16'sh1234, 1'b0, 1'b0, '{default: '0}},
    '{MODE_CAL, 16'sd0, 16'sd0, 1'b0, 1'b0, '{default: '0}},
    '{MODE_APPLY, 16'sd3, 16'sd3, 1'b0, 1'b0, '{default: '0}},
    '{MODE_CAL, 16'sd2, 16'sd2, 1'b1, 1'b0, '{default: '0}},
    '{MODE_APPLY, 16'sd9, -16'sd7, 1'b0, 1'b0, '{default: '0}},
    '{MODE_APPLY, -16'sd7, 16'sd9, 1'b0, 1'b0, '{default: '0}},
    '{MODE_APPLY, 16'sd8, -16'sd6, 1'b0, 1'b0, '{default: '0}},
    '{MODE_APPLY, VAL_MAX, VAL_MIN, 1'b0, 1'b0, '{default: '0}},
    '{MODE_CAL, 16'sd5, 16'sd0, 1'b0, 1'b0, '{default: '0}},
    '{MODE_CAL, 16'sd5, 16'sd10, 1'b1, 1'b0, '{default: '0}},
    '{MODE_APPLY, 16'sd5, 16'sd5, 1'b0, 1'b0, '{default: '0}},
    '{MODE_APPLY, VAL_MIN, VAL_MAX, 1'b0, 1'b0, '{default: '0}},
    '{MODE_CAL, 16'sd7, -16'sd3, 1'b1, 1'b0, '{default: '0}},
    '{MODE_APPLY, 16'sd1, 16'sd2, 1'b0, 1'b0, '{default: '0}},
    '{MODE_CAL, -16'sd1, -16'sd1, 1'b0, 1'b0, '{default: '0}},
    '{MODE_CAL, 16'sd1, 16'sd1, 1'b1, 1'b0, '{default: '0}},
    '{MODE_APPLY, -16'sd1, 16'sd1, 1'b0, 1'b0, '{default: '0}},
    '{MODE_APPLY, 16'sd0, VAL_MAX, 1'b1, 1'b0, '{default: '0}}
  };

  magnetometer_min_max_calibration i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .x_sample_i    (x_sample_i),
    .y_sample_i    (y_sample_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .norm_x_o      (norm_x_o),
    .norm_y_o      (norm_y_o),
    .x_zero_span_o (x_zero_span_o),
    .y_zero_span_o (y_zero_span_o),
    .saturated_o   (saturated_o),
    .x_high_o      (x_high_o),
    .x_low_o       (x_low_o),
    .y_high_o      (y_high_o),
    .y_low_o       (y_low_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // One axis of (2v - high - low) / (high - low), truncated toward zero.
  function automatic sample_t norm_axis(input sample_t v, input sample_t hi,
                                        input sample_t lo, output logic zero,
                                        inout logic sat);
    longint          num;
    longint          den;
    longint unsigned un;
    longint unsigned ud;
    longint unsigned q;
    num = 2 * longint'(v) - longint'(hi) - longint'(lo);
    den = longint'(hi) - longint'(lo);
    zero = (den == 0);
    if (zero) return '0;
    un = (num < 0) ? -num : num;
    un = un << FRAC_BITS;
    ud = (den < 0) ? -den : den;
    q = un / ud;
    if ((num < 0) == (den < 0)) begin
      if (q > longint'(VAL_MAX)) begin
        sat = 1'b1;
        return VAL_MAX;
      end
      return sample_t'(q);
    end
    if (q > -longint'(VAL_MIN)) begin
      sat = 1'b1;
      return VAL_MIN;
    end
    return sample_t'(-longint'(q));
  endfunction

  function automatic mag_result_t predict_result(input logic mode, input sample_t x_raw,
                                                 input sample_t y_raw, input logic last);
    mag_result_t r;
    sample_t     x;
    sample_t     y;
    x = sample_t'($signed(x_raw[SAMPLE_BITS-1:0]));
    y = sample_t'($signed(y_raw[SAMPLE_BITS-1:0]));
    r = '{default: '0};
    r.kind = mode;
    if (mode == MODE_CAL) begin
      if (x > trk_xh) trk_xh = x;
      if (x < trk_xl) trk_xl = x;
      if (y > trk_yh) trk_yh = y;
      if (y < trk_yl) trk_yl = y;
    end else begin
      r.nx = norm_axis(x, cal_xh, cal_xl, r.zx, r.sat);
      r.ny = norm_axis(y, cal_yh, cal_yl, r.zy, r.sat);
    end
    r.xh = trk_xh;
    r.xl = trk_xl;
    r.yh = trk_yh;
    r.yl = trk_yl;
    // The committed extremes are reported before the trackers restart.
    if (mode == MODE_CAL && last) begin
      cal_xh = trk_xh;
      cal_xl = trk_xl;
      cal_yh = trk_yh;
      cal_yl = trk_yl;
      trk_xh = VAL_MIN;
      trk_xl = VAL_MAX;
      trk_yh = VAL_MIN;
      trk_yl = VAL_MAX;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("%0t: result %0d: %s is %0d, expected %0d",
               $time, results_seen, what, got, want);
  endtask

  task automatic check_result();
    mag_result_t want;
    results_seen++;
    if (pending_q.size() == 0) begin
      report_mismatch("unrequested result_kind", result_kind_o, 0);
      return;
    end
    want = pending_q.pop_front();
    if (result_kind_o !== want.kind) report_mismatch("result_kind", result_kind_o, want.kind);
    if (norm_x_o !== want.nx) report_mismatch("norm_x", norm_x_o, want.nx);
    if (norm_y_o !== want.ny) report_mismatch("norm_y", norm_y_o, want.ny);
    if (x_zero_span_o !== want.zx) report_mismatch("x_zero_span", x_zero_span_o, want.zx);
    if (y_zero_span_o !== want.zy) report_mismatch("y_zero_span", y_zero_span_o, want.zy);
    if (saturated_o !== want.sat) report_mismatch("saturated", saturated_o, want.sat);
    if (x_high_o !== want.xh) report_mismatch("x_high", x_high_o, want.xh);
    if (x_low_o !== want.xl) report_mismatch("x_low", x_low_o, want.xl);
    if (y_high_o !== want.yh) report_mismatch("y_high", y_high_o, want.yh);
    if (y_low_o !== want.yl) report_mismatch("y_low", y_low_o, want.yl);
  endtask

  // Valid is left high after acceptance; the next call either keeps it high
  // with a new request or lowers it for a gap.
  task automatic send_request(input logic mode, input sample_t x, input sample_t y,
                              input logic last, input bit typed, input mag_result_t want);
    mag_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    x_sample_i <= x;
    y_sample_i <= y;
    last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = predict_result(mode, x, y, last);
    if (typed) pending_q.push_back(want);
    else pending_q.push_back(predicted);
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic int pick_radius();
    case ($urandom_range(3))
      0: return $urandom_range(3);
      1: return $urandom_range(300);
      2: return $urandom_range(8000);
      default: return 32767;
    endcase
  endfunction

  function automatic sample_t pick_sample(input int center, input int radius);
    int v;
    v = center + int'($urandom_range(2 * radius)) - radius;
    if (v > VAL_MAX) v = VAL_MAX;
    if (v < VAL_MIN) v = VAL_MIN;
    return sample_t'(v);
  endfunction

  // Mostly calibration sweeps closed by last, followed by a few apply
  // requests that may fall well outside the calibrated span. Some sweeps
  // are left open, and some requests are pure noise.
  task automatic run_random(input int count);
    int sent;
    int shape;
    int n;
    int spread;
    int center_x;
    int center_y;
    int rad_x;
    int rad_y;
    sent = 0;
    while (sent < count) begin
      shape = $urandom_range(9);
      center_x = int'(sample_t'($urandom));
      center_y = int'(sample_t'($urandom));
      rad_x = pick_radius();
      rad_y = pick_radius();
      if (shape <= 7) begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
          send_request(MODE_CAL, pick_sample(center_x, rad_x), pick_sample(center_y, rad_y),
                       (shape != 7) && (i == n - 1), 1'b0, blank_result);
        sent += n;
        n = $urandom_range(1, 6);
        spread = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          send_request(MODE_APPLY, pick_sample(center_x, spread * rad_x + 1),
                       pick_sample(center_y, spread * rad_y + 1),
                       logic'($urandom_range(1)), 1'b0, blank_result);
        sent += n;
      end else begin
        send_request(logic'($urandom_range(1)), sample_t'($urandom), sample_t'($urandom),
                     logic'($urandom_range(1)), 1'b0, blank_result);
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_result();
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, pending_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = MODE_CAL;
    x_sample_i = '0;
    y_sample_i = '0;
    last_i = 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 52;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_request(directed_rows[i].mode, directed_rows[i].x, directed_rows[i].y,
                   directed_rows[i].last, directed_rows[i].typed, directed_rows[i].want);
    run_random(RANDOM_ITEMS / 3);
    // Hold off the sender until the block has delivered everything.
    wait_results_drained();

    send_idle_pct = 52;
    recv_idle_pct = 34;
    run_random(RANDOM_ITEMS / 3);
    wait_results_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
hdl/mmcal_pkg.sv
hdl/magnetometer_min_max_calibration.sv
test/testbench.sv
